/* design/prl_pkg.sv */
// Package for the patterned line rasterizer: codes, field widths and shared structs.
// No dependencies; imported by every other design file.
package prl_pkg;

    localparam int COORD_W    = 12;
    localparam int DELTA_W    = 13;
    localparam int ERR_W      = 15;
    localparam int PATTERN_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 2;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        WM_REPLACE     = 2'd0,
        WM_TRANSPARENT = 2'd1,
        WM_XOR         = 2'd2,
        WM_REV_TRANSP  = 2'd3
    } t_wmode;

    typedef enum logic [1:0] {
        ACT_KEEP   = 2'd0,
        ACT_BLACK  = 2'd1,
        ACT_WHITE  = 2'd2,
        ACT_TOGGLE = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR  = CFG_IDX_W'(1);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_cmd                  cmd;
        t_coord                start_x;
        t_coord                start_y;
        t_coord                end_x;
        t_coord                end_y;
        logic [PATTERN_W-1:0]  dash_pattern;
        logic                  dash_enable;
    } t_item;

    typedef struct packed {
        t_coord                    cur_x;
        t_coord                    cur_y;
        t_coord                    target_x;
        t_coord                    target_y;
        logic signed [ERR_W-1:0]   err_acc;
        logic [DELTA_W-1:0]        twice_dx;
        logic [DELTA_W-1:0]        twice_dy;
        logic signed [1:0]         dir_x;
        logic signed [1:0]         dir_y;
        logic                      x_major;
        logic                      line_active;
        logic [PATTERN_W-1:0]      held_pattern;
        logic                      held_dash_enable;
    } t_line_state;

    // Pixel produced by one step, before the write mode is applied
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
        logic   drawn;   // 0: forced keep (step with no line)
    } t_pixel_pos;

endpackage

/* design/prl_ifs.sv */
// Valid/ready channel interfaces: input items, result pixels and register writes.
// Depends on prl_pkg.
interface prl_item_if;
    import prl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    t_coord                start_x;
    t_coord                start_y;
    t_coord                end_x;
    t_coord                end_y;
    logic [PATTERN_W-1:0]  dash_pattern;
    logic                  dash_enable;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, dash_pattern,
                    dash_enable, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, dash_pattern,
                    dash_enable, output ready);
endinterface

interface prl_pixel_if;
    import prl_pkg::*;
    logic        valid;
    logic        ready;
    t_coord      pix_x;
    t_coord      pix_y;
    logic [1:0]  action;
    logic        last;

    modport source (output valid, pix_x, pix_y, action, last, input ready);
    modport sink   (input valid, pix_x, pix_y, action, last, output ready);
endinterface

interface prl_cfg_if;
    import prl_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/prl_line_step.sv */
// One Bresenham step: line set-up on start, error update on step.
// Depends on prl_pkg.
module prl_line_step (
    input  prl_pkg::t_item       i_item,
    input  prl_pkg::t_line_state i_state,
    output prl_pkg::t_line_state o_state,
    output prl_pkg::t_pixel_pos  o_pos
);
    import prl_pkg::*;

    // set-up
    logic                      swap;
    t_coord                    sx0, sy0, sx1, sy1;
    logic signed [DELTA_W-1:0] dx, dy;
    logic [COORD_W-1:0]        adx, ady;
    logic [DELTA_W-1:0]        tdx, tdy;
    logic                      xm;
    logic signed [ERR_W-1:0]   err_init;

    // step
    logic                      take_minor;
    logic signed [ERR_W-1:0]   err_mid;
    t_coord                    nx, ny;

    always_comb begin
        swap = (i_item.start_x > i_item.end_x) || (i_item.start_y > i_item.end_y);
        sx0  = swap ? i_item.end_x   : i_item.start_x;
        sy0  = swap ? i_item.end_y   : i_item.start_y;
        sx1  = swap ? i_item.start_x : i_item.end_x;
        sy1  = swap ? i_item.start_y : i_item.end_y;
        dx   = {sx1[COORD_W-1], sx1} - {sx0[COORD_W-1], sx0};
        dy   = {sy1[COORD_W-1], sy1} - {sy0[COORD_W-1], sy0};
        adx  = dx[DELTA_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady  = dy[DELTA_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        tdx  = {adx, 1'b0};
        tdy  = {ady, 1'b0};
        xm   = (tdx >= tdy);
        err_init = xm ? $signed({2'b00, tdy}) - $signed({3'b000, adx})
                      : $signed({2'b00, tdx}) - $signed({3'b000, ady});

        // on an error tie the minor axis steps only when the major axis heads positive
        if (i_state.x_major) begin
            take_minor = (i_state.err_acc > 0) ||
                         ((i_state.err_acc == 0) && (i_state.dir_x == 2'sd1));
        end else begin
            take_minor = (i_state.err_acc > 0) ||
                         ((i_state.err_acc == 0) && (i_state.dir_y == 2'sd1));
        end
        err_mid = i_state.err_acc;
        nx      = i_state.cur_x;
        ny      = i_state.cur_y;
        if (i_state.x_major) begin
            if (take_minor) begin
                err_mid = err_mid - $signed({2'b00, i_state.twice_dx});
                ny      = ny + {{(COORD_W-2){i_state.dir_y[1]}}, i_state.dir_y};
            end
            err_mid = err_mid + $signed({2'b00, i_state.twice_dy});
            nx      = nx + {{(COORD_W-2){i_state.dir_x[1]}}, i_state.dir_x};
        end else begin
            if (take_minor) begin
                err_mid = err_mid - $signed({2'b00, i_state.twice_dy});
                nx      = nx + {{(COORD_W-2){i_state.dir_x[1]}}, i_state.dir_x};
            end
            err_mid = err_mid + $signed({2'b00, i_state.twice_dx});
            ny      = ny + {{(COORD_W-2){i_state.dir_y[1]}}, i_state.dir_y};
        end

        o_state = i_state;
        o_pos   = '{x: i_state.cur_x, y: i_state.cur_y, last: 1'b1, drawn: 1'b0};
        if (i_item.cmd == CMD_START) begin
            o_state.cur_x            = sx0;
            o_state.cur_y            = sy0;
            o_state.target_x         = sx1;
            o_state.target_y         = sy1;
            o_state.twice_dx         = tdx;
            o_state.twice_dy         = tdy;
            o_state.dir_x            = (dx > 0) ? 2'sd1 : ((dx < 0) ? -2'sd1 : 2'sd0);
            o_state.dir_y            = (dy > 0) ? 2'sd1 : ((dy < 0) ? -2'sd1 : 2'sd0);
            o_state.x_major          = xm;
            o_state.err_acc          = err_init;
            o_state.held_pattern     = i_item.dash_pattern;
            o_state.held_dash_enable = i_item.dash_enable;
            o_pos.last  = xm ? (sx0 == sx1) : (sy0 == sy1);
            o_pos.drawn = 1'b1;
            o_state.line_active = !o_pos.last;
        end else if (i_state.line_active) begin
            o_state.cur_x   = nx;
            o_state.cur_y   = ny;
            o_state.err_acc = err_mid;
            o_pos.last  = i_state.x_major ? (nx == i_state.target_x)
                                          : (ny == i_state.target_y);
            o_pos.drawn = 1'b1;
            o_state.line_active = !o_pos.last;
        end
        o_pos.x = o_state.cur_x;
        o_pos.y = o_state.cur_y;
    end

endmodule

/* design/prl_pixel_shade.sv */
// Pixel colour from pen, dash pattern and write mode, with screen clipping.
// Depends on prl_pkg.
module prl_pixel_shade #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 400
) (
    input  prl_pkg::t_pixel_pos              i_pos,
    input  logic [prl_pkg::PATTERN_W-1:0]    i_pattern,
    input  logic                             i_dash_enable,
    input  prl_pkg::t_wmode                  i_write_mode,
    input  logic                             i_pen_color,
    output prl_pkg::t_action                 o_action
);
    import prl_pkg::*;

    // one bit wider than a coordinate so a full 2048 wide screen still fits
    localparam logic [COORD_W:0] X_LIM = (COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [COORD_W:0] Y_LIM = (COORD_W+1)'(SCREEN_HEIGHT);

    logic on_screen;
    logic ink;   // 1 black

    always_comb begin
        on_screen = !i_pos.x[COORD_W-1] && !i_pos.y[COORD_W-1] &&
                    ({1'b0, i_pos.x} < X_LIM) && ({1'b0, i_pos.y} < Y_LIM);
        ink = i_pen_color ^ (i_dash_enable && !i_pattern[i_pos.x[3:0]]);
        case (i_write_mode)
            WM_REPLACE:     o_action = ink ? ACT_BLACK  : ACT_WHITE;
            WM_TRANSPARENT: o_action = ink ? ACT_BLACK  : ACT_KEEP;
            WM_XOR:         o_action = ink ? ACT_TOGGLE : ACT_KEEP;
            WM_REV_TRANSP:  o_action = ink ? ACT_KEEP   : ACT_BLACK;
            default:        o_action = ACT_KEEP;
        endcase
        if (!on_screen || !i_pos.drawn) begin
            o_action = ACT_KEEP;
        end
    end

endmodule

/* design/patterned_line_rasterizer_top.sv */
// Patterned line rasterizer top level: Bresenham line generator, one pixel per
// transfer, with an input register, the line state and an output register.
// Takes in one item transfer every clock while the pixel output is not stalled,
// and gives one pixel transfer for each, through the input register and then the
// output register. The sustained rate is one item per cycle, set by the line
// state update: the error accumulator add-and-compare plus the one-step coordinate
// advance all complete between the input register and the output register. Stalls
// at the pixel output hold the pipeline; the input register frees as soon as its
// item moves on. Register writes (write mode, pen colour) are always taken.
// Depends on prl_pkg, prl_ifs, prl_line_step and prl_pixel_shade.
module patterned_line_rasterizer_top #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 400
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prl_item_if.sink     i_item,
    prl_cfg_if.sink      i_cfg,
    prl_pixel_if.source  o_pixel
);
    import prl_pkg::*;

    // input stage
    logic        r_in_vld;
    t_item       r_in;
    // line state, updated as an item leaves the input stage
    t_line_state r_state;
    t_line_state n_state;
    t_pixel_pos  n_pos;
    t_action     n_action;
    // output stage
    logic        r_out_vld;
    t_coord      r_pix_x;
    t_coord      r_pix_y;
    t_action     r_action;
    logic        r_last;
    // registers
    t_wmode      r_write_mode;
    logic        r_pen_color;

    logic        advance;
    logic        in_fire;

    assign advance = r_in_vld && (!r_out_vld || o_pixel.ready);
    assign i_item.ready = !r_in_vld || advance;
    assign in_fire = i_item.valid && i_item.ready;
    assign i_cfg.ready = 1'b1;

    // step logic sees the registered item and the current line state
    prl_line_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_pos   (n_pos)
    );

    // a start uses its own pattern, hence the next state's copy
    prl_pixel_shade #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_shade (
        .i_pos         (n_pos),
        .i_pattern     (n_state.held_pattern),
        .i_dash_enable (n_state.held_dash_enable),
        .i_write_mode  (r_write_mode),
        .i_pen_color   (r_pen_color),
        .o_action      (n_action)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (in_fire) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_pixel.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.cmd          <= t_cmd'(i_item.cmd);
            r_in.start_x      <= i_item.start_x;
            r_in.start_y      <= i_item.start_y;
            r_in.end_x        <= i_item.end_x;
            r_in.end_y        <= i_item.end_y;
            r_in.dash_pattern <= i_item.dash_pattern;
            r_in.dash_enable  <= i_item.dash_enable;
        end
        if (advance) begin
            r_pix_x  <= n_pos.x;
            r_pix_y  <= n_pos.y;
            r_action <= n_action;
            r_last   <= n_pos.last;
        end
    end

    // configuration registers; unknown indices are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_mode <= WM_REPLACE;
            r_pen_color  <= 1'b1;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_WRITE_MODE) begin
                r_write_mode <= t_wmode'(i_cfg.data[1:0]);
            end
            if (i_cfg.index == CFG_PEN_COLOR) begin
                r_pen_color <= i_cfg.data[0];
            end
        end
    end

    assign o_pixel.valid  = r_out_vld;
    assign o_pixel.pix_x  = r_pix_x;
    assign o_pixel.pix_y  = r_pix_y;
    assign o_pixel.action = r_action;
    assign o_pixel.last   = r_last;

    // the pending pixel is always the newest one, so last mirrors the line state
    a_last_vs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_last != r_state.line_active))
        else $error("last flag disagrees with line state");

    // pixels with a negative coordinate never touch the frame buffer
    a_clip_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_pix_x[COORD_W-1] || r_pix_y[COORD_W-1])) |-> (r_action == ACT_KEEP))
        else $error("negative coordinate pixel not kept");

    // a held item is neither lost nor altered while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in)))
        else $error("input stage lost or changed a stalled item");

endmodule

/* tb/patterned_line_rasterizer_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for patterned_line_rasterizer_top: drives line starts and steps and predicts each
// pixel transfer with its own Bresenham tracer. Checks the pixel stream field by field.
// Depends on prl_pkg, prl_ifs and the design top level.
module patterned_line_rasterizer_top_tb;
    import prl_pkg::*;

    localparam int SCREEN_W     = 640;
    localparam int SCREEN_H     = 400;
    localparam int PIPE_LATENCY = 2;        // input register then output register
    localparam int STALL_LIMIT  = 4000;     // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS = 1500;
    localparam int REPORT_MAX   = 10;
    localparam int COORD_MAX    = 2**(COORD_W-1) - 1;
    localparam int COORD_MIN    = -(2**(COORD_W-1));

    // Highest register index: decodes to nothing, so a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = '1;

    typedef struct {
        t_coord  x;
        t_coord  y;
        t_action act;
        logic    last;
    } t_pixel_exp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    prl_item_if  item_if ();
    prl_cfg_if   cfg_if ();
    prl_pixel_if pix_if ();

    patterned_line_rasterizer_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .i_cfg   (cfg_if),
        .o_pixel (pix_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Line tracer: our own copy of the register settings and line state,
    // advanced once for every item transfer.
    // ------------------------------------------------------------------
    t_wmode      pen_mode   = WM_REPLACE;
    logic        pen_ink    = 1'b1;
    int          ln_x       = 0;
    int          ln_y       = 0;
    int          ln_tx      = 0;
    int          ln_ty      = 0;
    int          ln_err     = 0;
    int          ln_2dx     = 0;
    int          ln_2dy     = 0;
    int          ln_sx      = 0;
    int          ln_sy      = 0;
    bit          ln_x_major = 1'b0;
    bit          ln_active  = 1'b0;
    logic [15:0] ln_pattern = '0;
    logic        ln_dash    = 1'b0;

    t_pixel_exp  expected_pixels_q [$];

    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int items_sent     = 0;
    int starts_sent    = 0;
    int pixels_checked = 0;
    int line_ends_seen = 0;
    int reg_writes     = 0;
    int error_count    = 0;
    int stall_cycles   = 0;

    // Colour after the dash pattern, folded through the write mode.
    // Anything off the screen is left alone.
    function automatic t_action pixel_action(input int x, input int y);
        logic ink;
        if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return ACT_KEEP;
        ink = pen_ink;
        if (ln_dash && !ln_pattern[x[3:0]]) ink = ~ink;
        case (pen_mode)
            WM_REPLACE:     return ink ? ACT_BLACK  : ACT_WHITE;
            WM_TRANSPARENT: return ink ? ACT_BLACK  : ACT_KEEP;
            WM_XOR:         return ink ? ACT_TOGGLE : ACT_KEEP;
            default:        return ink ? ACT_KEEP   : ACT_BLACK;
        endcase
    endfunction

    // The end test runs along the major axis only
    function automatic bit line_done();
        return ln_x_major ? (ln_x == ln_tx) : (ln_y == ln_ty);
    endfunction

    function automatic t_pixel_exp trace_line_pixel(input t_item it);
        int         x0, y0, x1, y1, tmp, dx, dy;
        t_pixel_exp px;
        if (it.cmd == CMD_START) begin
            x0 = it.start_x;
            y0 = it.start_y;
            x1 = it.end_x;
            y1 = it.end_y;
            // either coordinate running backwards swaps the whole pair
            if (x0 > x1 || y0 > y1) begin
                tmp = x0; x0 = x1; x1 = tmp;
                tmp = y0; y0 = y1; y1 = tmp;
            end
            dx         = x1 - x0;
            dy         = y1 - y0;
            ln_sx      = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
            ln_sy      = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
            ln_2dx     = ((dx < 0) ? -dx : dx) * 2;
            ln_2dy     = ((dy < 0) ? -dy : dy) * 2;
            ln_x_major = ln_2dx >= ln_2dy;
            ln_err     = ln_x_major ? ln_2dy - ln_2dx / 2 : ln_2dx - ln_2dy / 2;
            ln_x       = x0;
            ln_y       = y0;
            ln_tx      = x1;
            ln_ty      = y1;
            ln_pattern = it.dash_pattern;
            ln_dash    = it.dash_enable;
            px.last    = line_done();
            ln_active  = !px.last;
            px.act     = pixel_action(ln_x, ln_y);
        end else if (!ln_active) begin
            // nothing to draw: repeat the current position, untouched
            px.last = 1'b1;
            px.act  = ACT_KEEP;
        end else begin
            // a zero error only moves the minor axis when heading positive
            if (ln_x_major) begin
                if (ln_err > 0 || (ln_err == 0 && ln_sx > 0)) begin
                    ln_err -= ln_2dx;
                    ln_y   += ln_sy;
                end
                ln_err += ln_2dy;
                ln_x   += ln_sx;
            end else begin
                if (ln_err > 0 || (ln_err == 0 && ln_sy > 0)) begin
                    ln_err -= ln_2dy;
                    ln_x   += ln_sx;
                end
                ln_err += ln_2dx;
                ln_y   += ln_sy;
            end
            px.last = line_done();
            if (px.last) ln_active = 1'b0;
            px.act = pixel_action(ln_x, ln_y);
        end
        px.x = t_coord'(ln_x);
        px.y = t_coord'(ln_y);
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers. Inputs move on the falling edge; transfers are
    // seen on the rising edge.
    // ------------------------------------------------------------------
    task automatic send_item(input t_item it);
        t_pixel_exp px;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge i_clk);
        end
        item_if.cmd          = it.cmd;
        item_if.start_x      = it.start_x;
        item_if.start_y      = it.start_y;
        item_if.end_x        = it.end_x;
        item_if.end_y        = it.end_y;
        item_if.dash_pattern = it.dash_pattern;
        item_if.dash_enable  = it.dash_enable;
        item_if.valid        = 1'b1;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        px = trace_line_pixel(it);
        expected_pixels_q.push_back(px);
        items_sent++;
        if (it.cmd == CMD_START) starts_sent++;
    endtask

    // Hold the item channel off until every predicted pixel has been seen
    task automatic wait_for_pixels();
        @(negedge i_clk);
        item_if.valid = 1'b0;
        while (expected_pixels_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.index = idx;
        cfg_if.data  = data;
        cfg_if.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        // upper data bits and unknown indexes are ignored
        if (idx == CFG_WRITE_MODE) pen_mode = t_wmode'(data);
        else if (idx == CFG_PEN_COLOR) pen_ink = data[0];
        reg_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_item random_item();
        t_item it;
        it.cmd          = $urandom_range(1) ? CMD_STEP : CMD_START;
        it.start_x      = t_coord'($urandom);
        it.start_y      = t_coord'($urandom);
        it.end_x        = t_coord'($urandom);
        it.end_y        = t_coord'($urandom);
        it.dash_pattern = PATTERN_W'($urandom);
        it.dash_enable  = 1'($urandom);
        return it;
    endfunction

    task automatic draw_start(input int x0, input int y0, input int x1, input int y1,
                              input logic [PATTERN_W-1:0] dash_bits, input logic dash);
        t_item it;
        it.cmd          = CMD_START;
        it.start_x      = t_coord'(x0);
        it.start_y      = t_coord'(y0);
        it.end_x        = t_coord'(x1);
        it.end_y        = t_coord'(y1);
        it.dash_pattern = dash_bits;
        it.dash_enable  = dash;
        send_item(it);
    endtask

    // Step fields other than the command carry junk; the block must ignore them
    task automatic draw_steps(input int count);
        t_item it;
        for (int i = 0; i < count; i++) begin
            it     = random_item();
            it.cmd = CMD_STEP;
            send_item(it);
        end
    endtask

    // Mostly on screen, some hugging the edges, some anywhere in range
    function automatic int pick_coord(input int span);
        case ($urandom_range(9))
            0, 1:    return int'($urandom_range(4095)) + COORD_MIN;
            2, 3:    return ($urandom_range(1) ? span : 0) + int'($urandom_range(12)) - 6;
            default: return int'($urandom_range(span - 1));
        endcase
    endfunction

    function automatic int clamp_coord(input int v);
        return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
    endfunction

    function automatic logic [PATTERN_W-1:0] pick_pattern();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return PATTERN_W'($urandom);
        endcase
    endfunction

    // Whole lines with random content make up most of the traffic; the rest is
    // long lines cut short by the next start, and lone random items.
    task automatic run_random_lines(input int count);
        int stop_at, x0, y0, x1, y1, dx, dy, len, kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                x0 = clamp_coord(pick_coord(SCREEN_W));
                y0 = clamp_coord(pick_coord(SCREEN_H));
                dx = int'($urandom_range(30)) - 15;
                dy = int'($urandom_range(30)) - 15;
                case ($urandom_range(4))
                    0:       dy = 0;
                    1:       dx = 0;
                    2:       dy = $urandom_range(1) ? dx : -dx;
                    default: ;
                endcase
                x1  = clamp_coord(x0 + dx);
                y1  = clamp_coord(y0 + dy);
                len = (x1 > x0) ? x1 - x0 : x0 - x1;
                dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
                if (dy > len) len = dy;
                if ($urandom_range(99) < 15) len = $urandom_range(len);
                else if ($urandom_range(99) < 30) len += $urandom_range(3, 1);
                draw_start(x0, y0, x1, y1, pick_pattern(), 1'($urandom));
                draw_steps(len);
            end else if (kind < 85) begin
                draw_start(int'($urandom_range(4095)) + COORD_MIN,
                           int'($urandom_range(4095)) + COORD_MIN,
                           int'($urandom_range(4095)) + COORD_MIN,
                           int'($urandom_range(4095)) + COORD_MIN,
                           pick_pattern(), 1'($urandom));
                draw_steps($urandom_range(40));
            end else begin
                send_item(random_item());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset no line is active: a step reports 0,0, keep, last
    task automatic test_idle_step();
        draw_steps(1);
    endtask

    task automatic test_line_shapes();
        draw_start(10, 10, 10, 10, '1, 1'b1);              // one pixel, last at once
        draw_start(18, 5, 16, 5, '0, 1'b1);                // reversed, every dash bit clear
        draw_steps(2);
        draw_start(30, 30, 32, 31, 16'h5A5A, 1'b1);        // error tie heading positive
        draw_steps(2);
        draw_start(40, 41, 42, 40, 16'hA5A5, 1'b0);        // swap leaves x negative; tie held
        draw_steps(2);
        draw_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, '1, 1'b1);
        draw_steps(1);
        // new start abandons the long diagonal; vertical at the far corner
        draw_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 16'h8001, 1'b1);
        draw_steps(1);
        // last visible pixel, then off the corner, then a step with nothing left
        draw_start(SCREEN_W - 1, SCREEN_H - 1, SCREEN_W, SCREEN_H, 16'h8000, 1'b1);
        draw_steps(2);
    endtask

    // Every write mode against both dash polarities. The pen write carries the
    // mode value, so its upper bit is set half the time and must be ignored.
    task automatic test_write_modes();
        t_wmode mode;
        mode = mode.first();
        repeat (4) begin
            wait_for_pixels();
            write_reg(CFG_WRITE_MODE, mode);
            write_reg(CFG_PEN_COLOR, mode);
            write_reg(CFG_UNUSED_TOP, '1);
            draw_start(7, 3, 8, 3, 16'h0080, 1'b1);        // bit 7 set, bit 8 clear
            draw_steps(1);
            mode = mode.next();
        end
    endtask

    // Three stall profiles, each cycling through the write modes
    task automatic test_random_traffic();
        int src_pct  [3] = '{27, 69, 0};
        int sink_pct [3] = '{69, 27, 0};
        t_wmode mode;
        for (int p = 0; p < 3; p++) begin
            src_idle_pct  = src_pct[p];
            sink_idle_pct = sink_pct[p];
            mode = mode.first();
            repeat (4) begin
                wait_for_pixels();
                write_reg(CFG_WRITE_MODE, mode);
                write_reg(CFG_PEN_COLOR, CFG_DATA_W'($urandom));
                if ($urandom_range(3) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(15, 2)), CFG_DATA_W'($urandom));
                run_random_lines(RANDOM_ITEMS / 12);
                mode = mode.next();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Pixel sink: random back-pressure, set per profile
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        pix_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Each pixel transfer is compared with the oldest prediction
    always @(posedge i_clk) begin : pixel_check
        t_pixel_exp px;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            pixels_checked++;
            if (expected_pixels_q.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: unexpected pixel x=%0d y=%0d action=%0d last=%0d",
                             $time, pix_if.pix_x, pix_if.pix_y, pix_if.action, pix_if.last);
            end else begin
                px = expected_pixels_q.pop_front();
                if (px.last) line_ends_seen++;
                if (pix_if.pix_x !== px.x || pix_if.pix_y !== px.y ||
                    pix_if.action !== px.act || pix_if.last !== px.last) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: pixel mismatch, expected x=%0d y=%0d action=%0d last=%0d, %s",
                                 $time, px.x, px.y, px.act, px.last,
                                 $sformatf("got x=%0d y=%0d action=%0d last=%0d",
                                           pix_if.pix_x, pix_if.pix_y, pix_if.action,
                                           pix_if.last));
                end
            end
        end
    end

    // Watchdog: item and register transfers count as progress, pixel transfers
    // only while a pixel is still owed, so a runaway pixel stream cannot hang the run
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (pix_if.valid && pix_if.ready && expected_pixels_q.size() != 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** patterned_line_rasterizer_top: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        item_if.valid        = 1'b0;
        item_if.cmd          = CMD_START;
        item_if.start_x      = '0;
        item_if.start_y      = '0;
        item_if.end_x        = '0;
        item_if.end_y        = '0;
        item_if.dash_pattern = '0;
        item_if.dash_enable  = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;

        // directed part runs under the first stall profile
        src_idle_pct  = 27;
        sink_idle_pct = 69;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_step();
        test_line_shapes();
        test_write_modes();
        test_random_traffic();

        wait_for_pixels();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("%0d items sent (%0d line starts), %0d pixel transfers checked, %0d line ends.",
                 items_sent, starts_sent, pixels_checked, line_ends_seen);
        $display("All write modes, both pen colours, %0d register writes, three stall profiles.",
                 reg_writes);
        if (error_count == 0 && expected_pixels_q.size() == 0) begin
            $display("** patterned_line_rasterizer_top: PASSED **");
        end else begin
            $display("%0d failures, %0d pixels outstanding", error_count,
                     expected_pixels_q.size());
            $display("** patterned_line_rasterizer_top: FAILED **");
        end
        $finish;
    end

endmodule
